[rtl/tts_pkg.sv]
// Shared types and constants for the texture tile swizzle address block.
// No dependencies; every other file in rtl/ imports this package.
package tts_pkg;

  localparam int unsigned ROW_W   = 10;
  localparam int unsigned COL_W   = 12;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DEST_W  = 22;
  localparam int unsigned WIDTH_W = 11;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = WIDTH_W;

  localparam int unsigned MAX_WIDTH_DEF   = 1024;
  localparam logic [WIDTH_W-1:0] WIDTH_RST = 11'd1024;

  typedef enum logic [MODE_W-1:0] {
    MODE_RGBA8 = 2'd0,
    MODE_C8    = 2'd1,
    MODE_C4    = 2'd2,
    MODE_DXT1  = 2'd3
  } tile_mode_e;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH = 1'd1;

  typedef struct packed {
    tile_mode_e         mode;
    logic [WIDTH_W-1:0] width;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row_index;
    logic [COL_W-1:0]  byte_column;
    logic [BYTE_W-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [DEST_W-1:0] dest_offset;
    logic [BYTE_W-1:0] data_out;
    logic              bad_position;
  } out_item_t;

endpackage

[rtl/tts_if.sv]
// Valid/ready channel interfaces for source bytes and tiled results.
// Depends on tts_pkg for field widths.
interface tts_in_if import tts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  row_index;
  logic [COL_W-1:0]  byte_column;
  logic [BYTE_W-1:0] data_in;

  modport source (output valid, row_index, byte_column, data_in, input ready);
  modport sink   (input valid, row_index, byte_column, data_in, output ready);
endinterface

interface tts_out_if import tts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DEST_W-1:0] dest_offset;
  logic [BYTE_W-1:0] data_out;
  logic              bad_position;

  modport source (output valid, dest_offset, data_out, bad_position, input ready);
  modport sink   (input valid, dest_offset, data_out, bad_position, output ready);
endinterface

[rtl/tts_cfg_regs.sv]
// Configuration registers: tiling mode and texture width.
// Depends on tts_pkg.
module tts_cfg_regs import tts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  tile_mode_e         mode_q;
  logic [WIDTH_W-1:0] width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_RGBA8;
      width_q <= WIDTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_MODE:  mode_q  <= tile_mode_e'(cfg_wdata_i[MODE_W-1:0]);
        CFG_IDX_WIDTH: width_q <= cfg_wdata_i[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.mode  = mode_q;
  assign cfg_o.width = width_q;

endmodule

[rtl/tts_addr_calc.sv]
// Tiled offset and byte transform for one source byte, purely combinational.
// Depends on tts_pkg.
module tts_addr_calc import tts_pkg::*; #(
  parameter int unsigned MaxWidth = MAX_WIDTH_DEF
) (
  input  cfg_t      cfg_i,
  input  in_item_t  item_i,
  output out_item_t res_o
);

  logic [ROW_W-1:0]   r;
  logic [COL_W-1:0]   c;
  logic [BYTE_W-1:0]  d;
  logic [WIDTH_W-1:0] w;
  logic [12:0]        row_bytes;
  logic [ROW_W-1:0]   row_base;
  logic [13:0]        tile_off;
  logic               misaligned;
  logic               bad;
  logic [DEST_W-1:0]  prod;
  logic [DEST_W-1:0]  dest;
  logic [BYTE_W-1:0]  dout;
  logic [BYTE_W-1:0]  nib_swap;
  logic [BYTE_W-1:0]  pair_rev;

  assign r = item_i.row_index;
  assign c = item_i.byte_column;
  assign d = item_i.data_in;
  assign w = cfg_i.width;

  assign nib_swap = {d[3:0], d[7:4]};
  assign pair_rev = {d[1:0], d[3:2], d[5:4], d[7:6]};

  // Tile-local offset fields never overlap, so the sum is a concatenation.
  always_comb begin
    row_bytes  = {2'b00, w};
    row_base   = {r[ROW_W-1:2], 2'b00};
    tile_off   = {c[11:3], r[1:0], c[2:0]};
    misaligned = (w[2:0] != 3'd0);
    dout       = d;
    case (cfg_i.mode)
      MODE_RGBA8: begin
        row_bytes  = {w, 2'b00};
        misaligned = (w[1:0] != 2'd0);
        tile_off   = {c[11:4], c[1], r[1:0], c[3:2], c[0]};
      end
      MODE_C8: ;
      MODE_C4: begin
        row_bytes = {3'b000, w[WIDTH_W-1:1]};
        row_base  = {r[ROW_W-1:3], 3'b000};
        // an in-row column stays below 512, so its top bit is always zero
        tile_off  = {c[10:2], r[2:0], c[1:0]};
        dout      = nib_swap;
      end
      MODE_DXT1: begin
        row_bytes = {1'b0, w, 1'b0};
        row_base  = {r[ROW_W-1:1], 1'b0};
        // color bytes swap within each 16-bit word; index bytes reverse pairs
        tile_off  = {1'b0, c[11:4], r[0], c[3], c[2], c[1], c[0] ^ ~c[2]};
        dout      = c[2] ? pair_rev : d;
      end
      default: ;
    endcase
  end

  assign bad  = (w > WIDTH_W'(MaxWidth)) || misaligned || ({1'b0, c} >= row_bytes);
  assign prod = DEST_W'(row_base) * DEST_W'(row_bytes);
  assign dest = prod + DEST_W'(tile_off);

  assign res_o.dest_offset  = bad ? '0 : dest;
  assign res_o.data_out     = bad ? '0 : dout;
  assign res_o.bad_position = bad;

endmodule

[rtl/texture_tile_swizzle_address.sv]
// Texture tile swizzle address: an accepted item goes to the input register, then to the
// result register; throughput 1 item per cycle while the output is not stalled, set by one
// multiply-add between the two registers. A stalled result blocks new items only once both
// registers are full. Reset clears both valid flags and sets mode rgba8, width 1024.
module texture_tile_swizzle_address import tts_pkg::*; #(
  parameter int unsigned MaxWidth = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  tts_in_if.sink                item_i,
  tts_out_if.source             result_o
);

  cfg_t      cfg;
  in_item_t  in_d;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t res_d;
  out_item_t res_q;
  logic      res_valid_q;
  logic      in_ready;
  logic      res_ready;

  tts_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  assign res_ready = !res_valid_q || result_o.ready;
  assign in_ready  = !in_valid_q || res_ready;

  assign in_d.row_index   = item_i.row_index;
  assign in_d.byte_column = item_i.byte_column;
  assign in_d.data_in     = item_i.data_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= item_i.valid;
      end
      if (res_ready) begin
        res_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && in_ready) begin
      in_q <= in_d;
    end
    if (in_valid_q && res_ready) begin
      res_q <= res_d;
    end
  end

  tts_addr_calc #(
    .MaxWidth(MaxWidth)
  ) u_calc (
    .cfg_i (cfg),
    .item_i(in_q),
    .res_o (res_d)
  );

  assign item_i.ready          = in_ready;
  assign result_o.valid        = res_valid_q;
  assign result_o.dest_offset  = res_q.dest_offset;
  assign result_o.data_out     = res_q.data_out;
  assign result_o.bad_position = res_q.bad_position;

endmodule

[rtl/tts_checker.sv]
// Port-level checks for texture_tile_swizzle_address, attached by bind.
// Depends on tts_pkg and the top level's channel interfaces.
module tts_checker import tts_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [DEST_W-1:0] dest_offset_i,
  input logic [BYTE_W-1:0] data_out_i,
  input logic              bad_position_i
);

  // Hold a stalled result unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(dest_offset_i) &&
      $stable(data_out_i) && $stable(bad_position_i))
    else $error("stalled result changed");

  // Flagged items carry zero payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && bad_position_i |-> dest_offset_i == '0 && data_out_i == '0)
    else $error("flagged item with nonzero payload");

  // An empty output side never blocks the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output empty");

  // A fresh result comes from an accepted item, via the input and result registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without matching item");

endmodule

bind texture_tile_swizzle_address tts_checker u_tts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (item_i.valid),
  .in_ready_i    (item_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .dest_offset_i (result_o.dest_offset),
  .data_out_i    (result_o.data_out),
  .bad_position_i(result_o.bad_position)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// Testbench for texture_tile_swizzle_address: streams source bytes under all tiling modes
// and many widths, predicts each tiled offset and byte, and checks results in order.
// Depends on tts_pkg, the tts_in_if / tts_out_if interfaces and the block's RTL.
module tb;
  import tts_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned SWEEP_PHASES   = 14;
  localparam int unsigned SWEEP_ITEMS    = 110;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  tts_in_if  src_ch ();
  tts_out_if dst_ch ();

  texture_tile_swizzle_address DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (src_ch),
    .result_o    (dst_ch)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the block's registers, updated as they are written
  tile_mode_e         cur_mode;
  logic [WIDTH_W-1:0] cur_width;

  out_item_t   tiled_expect_q[$];
  int unsigned bytes_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned flagged_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned settings_used = 0;
  int unsigned holds_asked   = 0;
  int unsigned holds_done    = 0;
  int unsigned burst_left    = 0;
  int unsigned idle_cycles   = 0;
  bit          sink_stalls   = 1'b1;
  bit          bursty        = 1'b1;

  function automatic int unsigned row_span(input tile_mode_e mode,
                                           input logic [WIDTH_W-1:0] width);
    case (mode)
      MODE_RGBA8: return 32'd4 * width;
      MODE_C8:    return 32'd0 + width;
      MODE_C4:    return 32'd0 + (width >> 1);
      default:    return 32'd2 * width;
    endcase
  endfunction

  function automatic out_item_t tile_address(input tile_mode_e mode,
                                             input logic [WIDTH_W-1:0] width,
                                             input in_item_t it);
    int unsigned w, r, c, span, px, blk, ofs;
    logic [2:0]  lane;
    out_item_t   res;
    w    = width;
    r    = it.row_index;
    c    = it.byte_column;
    span = row_span(mode, width);
    res  = '0;
    if (w > MAX_WIDTH_DEF || (w % ((mode == MODE_RGBA8) ? 4 : 8)) != 0 || c >= span) begin
      res.bad_position = 1'b1;
      return res;
    end
    res.data_out = it.data_in;
    case (mode)
      MODE_RGBA8: begin
        // AR half of the tile first, GB half 32 bytes later
        px  = c >> 2;
        ofs = (r & ~32'd3) * span + (px >> 2) * 64 + c[1] * 32 +
              ((r & 3) * 4 + (px & 3)) * 2 + c[0];
      end
      MODE_C8: begin
        ofs = (r & ~32'd3) * w + (c >> 3) * 32 + (r & 3) * 8 + (c & 7);
      end
      MODE_C4: begin
        ofs = (r & ~32'd7) * span + (c >> 2) * 32 + (r & 7) * 4 + (c & 3);
        res.data_out = {it.data_in[3:0], it.data_in[7:4]};
      end
      default: begin
        // swap bytes of each colour word, reverse the 2-bit fields of index bytes
        lane = c[2:0];
        blk  = c >> 3;
        if (lane < 3'd4) begin
          lane = lane ^ 3'd1;
        end else begin
          res.data_out = {it.data_in[1:0], it.data_in[3:2], it.data_in[5:4], it.data_in[7:6]};
        end
        ofs = (r >> 1) * (4 * w) + (blk >> 1) * 32 + (r & 1) * 16 + (blk & 1) * 8 + lane;
      end
    endcase
    res.dest_offset = ofs[DEST_W-1:0];
    return res;
  endfunction

  task automatic send_byte(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                           input logic [BYTE_W-1:0] data);
    in_item_t    it;
    int unsigned gap;
    it = '{row_index: row, byte_column: col, data_in: data};
    if (bursty && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        src_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left != 0) burst_left--;
    src_ch.valid       <= 1'b1;
    src_ch.row_index   <= row;
    src_ch.byte_column <= col;
    src_ch.data_in     <= data;
    @(posedge clk_i);
    while (!src_ch.ready) @(posedge clk_i);
    tiled_expect_q.push_back(tile_address(cur_mode, cur_width, it));
    bytes_sent++;
  endtask

  // drain the pipe, then write mode and width on back-to-back edges
  task automatic apply_setting(input tile_mode_e mode, input logic [WIDTH_W-1:0] width);
    src_ch.valid <= 1'b0;
    while (tiled_expect_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_IDX_MODE;
    cfg_wdata_i <= CFG_DATA_W'(mode);
    @(posedge clk_i);
    cur_mode     = mode;
    cfg_idx_i   <= CFG_IDX_WIDTH;
    cfg_wdata_i <= width;
    @(posedge clk_i);
    cur_width = width;
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic test_reset_state();
    send_byte(10'd0, 12'd0, 8'h00);
    send_byte(10'd1023, 12'd4095, 8'hFF);
    send_byte(10'd514, 12'd1234, 8'h5A);
  endtask

  task automatic test_mode_corners();
    apply_setting(MODE_C8, 11'd1024);
    send_byte(10'd1023, 12'd1023, 8'h5A);
    send_byte(10'd5, 12'd1024, 8'h33);
    apply_setting(MODE_C4, 11'd1024);
    send_byte(10'd1023, 12'd511, 8'hC3);
    send_byte(10'd7, 12'd512, 8'h0F);
    apply_setting(MODE_DXT1, 11'd1024);
    send_byte(10'd1023, 12'd2047, 8'hE4);
    send_byte(10'd1022, 12'd2, 8'h1B);
    send_byte(10'd0, 12'd2048, 8'hFF);
    apply_setting(MODE_DXT1, 11'd8);
    send_byte(10'd1, 12'd15, 8'h96);
    send_byte(10'd1, 12'd3, 8'h69);
    apply_setting(MODE_RGBA8, 11'd4);
    send_byte(10'd3, 12'd15, 8'h81);
    send_byte(10'd3, 12'd16, 8'h81);
  endtask

  task automatic test_bad_widths();
    apply_setting(MODE_C8, 11'd12);
    send_byte(10'd0, 12'd0, 8'hAA);
    apply_setting(MODE_C4, 11'd0);
    send_byte(10'd0, 12'd0, 8'h55);
    apply_setting(MODE_C4, 11'd1032);
    send_byte(10'd0, 12'd0, 8'h77);
    apply_setting(MODE_DXT1, 11'd2047);
    send_byte(10'd0, 12'd5, 8'h12);
    apply_setting(MODE_RGBA8, 11'd6);
    send_byte(10'd0, 12'd0, 8'h34);
    apply_setting(MODE_RGBA8, 11'd2044);
    send_byte(10'd2, 12'd8, 8'h21);
  endtask

  task automatic test_random_sweep();
    tile_mode_e         mode;
    logic [WIDTH_W-1:0] width;
    logic [COL_W-1:0]   col;
    int unsigned        align, span, pick;
    for (int phase = 0; phase < SWEEP_PHASES; phase++) begin
      mode  = (phase < 8) ? tile_mode_e'(phase % 4) : tile_mode_e'($urandom_range(0, 3));
      align = (mode == MODE_RGBA8) ? 4 : 8;
      pick  = $urandom_range(0, 9);
      if (phase == 0 || phase == 5) width = 11'd1024;
      else if (phase == 1 || phase == 6) width = WIDTH_W'(align);
      else if (pick < 2) width = WIDTH_W'($urandom_range(0, 2047));
      else if (pick < 5) width = WIDTH_W'($urandom_range(1, 8) * align);
      else width = WIDTH_W'($urandom_range(1, 1024 / align) * align);
      sink_stalls = (phase % 5 != 4);
      apply_setting(mode, width);
      span = row_span(mode, width);
      if (span > 4096) span = 4096;
      for (int n = 0; n < SWEEP_ITEMS; n++) begin
        // keep most columns inside the row
        if (span != 0 && $urandom_range(0, 99) < 85) col = COL_W'($urandom_range(0, span - 1));
        else col = COL_W'($urandom);
        send_byte(ROW_W'($urandom), col, BYTE_W'($urandom));
      end
    end
  endtask

  task automatic test_backpressure();
    int unsigned span;
    apply_setting(MODE_DXT1, 11'd1024);
    span        = row_span(MODE_DXT1, 11'd1024);
    bursty      = 1'b0;
    sink_stalls = 1'b0;
    holds_asked++;
    repeat (160) send_byte(ROW_W'($urandom), COL_W'($urandom_range(0, span - 1)),
                           BYTE_W'($urandom));
    bursty = 1'b1;
  endtask

  // receiver pacing: runs of ready and stall, plus a long hold on request
  initial begin : sink_pacing
    bit          sink_open;
    int unsigned run_left;
    sink_open = 1'b1;
    run_left  = 0;
    dst_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_done != holds_asked) begin
        holds_done++;
        dst_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        if (run_left == 0) begin
          sink_open = !sink_open || !sink_stalls;
          run_left  = sink_open ? $urandom_range(1, 20) : $urandom_range(1, 8);
        end
        run_left--;
        dst_ch.ready <= sink_open;
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && dst_ch.valid && dst_ch.ready) begin
      results_seen++;
      if (dst_ch.bad_position) flagged_seen++;
      if (tiled_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb: unexpected result offset %0d data %02h flag %0b",
                   dst_ch.dest_offset, dst_ch.data_out, dst_ch.bad_position);
      end else begin
        want = tiled_expect_q.pop_front();
        if (dst_ch.dest_offset !== want.dest_offset || dst_ch.data_out !== want.data_out ||
            dst_ch.bad_position !== want.bad_position) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("tb: mismatch offset %0d/%0d data %02h/%02h flag %0b/%0b (got/want)",
                     dst_ch.dest_offset, want.dest_offset, dst_ch.data_out, want.data_out,
                     dst_ch.bad_position, want.bad_position);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (src_ch.valid && src_ch.ready) || (dst_ch.valid && dst_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: timeout, %0d results still pending", tiled_expect_q.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_IDX_MODE;
    cfg_wdata_i        <= '0;
    src_ch.valid       <= 1'b0;
    src_ch.row_index   <= '0;
    src_ch.byte_column <= '0;
    src_ch.data_in     <= '0;
    cur_mode  = MODE_RGBA8;
    cur_width = WIDTH_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_mode_corners();
    test_bad_widths();
    test_random_sweep();
    test_backpressure();

    src_ch.valid <= 1'b0;
    while (tiled_expect_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("tb: %0d bytes over %0d mode/width settings, all four modes, one long stall",
             bytes_sent, settings_used);
    $display("tb: %0d results checked, %0d flagged, %0d mismatches",
             results_seen, flagged_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
